FILE: rtl/cmbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbs_pkg
// shared payload types and codes of the cube map bilinear sampler
// ----------------------------------------------------------------------------
package cmbs_pkg;

  localparam int unsigned FACE_COUNT = 6;

  // face codes
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Z = 3'd2;
  localparam logic [2:0] FACE_NEG_Z = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_NEG_Y = 3'd5;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_FACE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FACE_HEIGHT = 2'd1;

  typedef struct packed {
    logic              kind;
    logic [2:0]        load_face;
    logic [5:0]        load_col;
    logic [5:0]        load_row;
    logic [7:0]        load_red;
    logic [7:0]        load_green;
    logic [7:0]        load_blue;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } item_t;

  typedef struct packed {
    logic [2:0] hit_face;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] value;
  } cfg_t;

endpackage

FILE: rtl/cmbs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbs channel interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface cmbs_item_if;
  logic           valid;
  logic           ready;
  cmbs_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface cmbs_result_if;
  logic             valid;
  logic             ready;
  cmbs_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface cmbs_cfg_if;
  logic          valid;
  logic          ready;
  cmbs_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

FILE: rtl/cmbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cmbs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 24576
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/cube_map_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube map bilinear sampler
// six faces of rgb888 texels in one texel ram; samples a direction with
// face select, per-axis division, wrap/clamp and bilinear blend
// ----------------------------------------------------------------------------
//  channel    dir  payload                               transaction
//  sample_i   in   item_t: load texel or sample dir      valid & ready
//  result_o   out  result_t: face and blended color      valid & ready
//  cfg_i      in   cfg_t: register index and value       valid & ready
//
//  in-range load transactions write the ram; loads are taken every cycle while idle
//  a sample passes a multiply step, the bit-serial divider and a wrap step,
//  then four ram reads at one per cycle and the blend
//  a sample that lands on black skips the divider and ram
//  the result register lets the next item in while a result waits
//  reset is async active low; the texel ram is not cleared
// ----------------------------------------------------------------------------
module cube_map_bilinear_sampler_top #(
  parameter int unsigned MAX_FACE_DIM = 64,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmbs_item_if.sink     sample_i,
  cmbs_result_if.source result_o,
  cmbs_cfg_if.sink      cfg_i
);
  import cmbs_pkg::*;

  localparam int unsigned DIM_W   = $clog2(MAX_FACE_DIM + 1);
  localparam int unsigned FACE_SZ = MAX_FACE_DIM * MAX_FACE_DIM;
  localparam int unsigned DEPTH   = FACE_COUNT * FACE_SZ;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned NUM_W   = 17;                   // magnitudes and 2m
  localparam int unsigned QW      = DIM_W + FRAC_BITS;    // quotient bits
  localparam int unsigned PROD_W  = NUM_W + DIM_W;
  localparam int unsigned TW      = 9 + FRAC_BITS;        // first blend level
  localparam int unsigned AW      = TW + FRAC_BITS + 2;   // second blend level
  localparam int unsigned CNT_W   = $clog2(QW + 1);
  localparam int unsigned DIM_RST = (MAX_FACE_DIM < 64) ? MAX_FACE_DIM : 64;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_WRAP, ST_READ, ST_BLEND1, ST_BLEND2, ST_OUT
  } state_e;

  state_e state_q;

  // registers
  logic [DIM_W-1:0] width_q, height_q;

  // sample context
  logic [2:0]        face_q;
  logic              black_q;
  logic [NUM_W-1:0]  num_u_q, num_v_q, dsr_q;
  logic [NUM_W-1:0]  rem_u_q, rem_v_q;
  logic [QW-1:0]     quo_u_q, quo_v_q;
  logic [CNT_W-1:0]  div_cnt_q;
  logic [DIM_W-1:0]  c0_q, c1_q, r0_q, r1_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [2:0]        rd_cnt_q;
  logic [23:0]       texel_q [4];
  logic [TW-1:0]     top_q [3];
  logic [TW-1:0]     bot_q [3];
  logic [7:0]        color_q [3];

  logic    out_valid_q;
  result_t out_data_q;

  // ---------------------------------------------------------------- handshakes
  logic in_acc, out_acc, cfg_acc, out_load;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign in_acc  = sample_i.valid && sample_i.ready;
  assign out_acc = result_o.valid && result_o.ready;
  assign cfg_acc = cfg_i.valid;
  // result register takes a new transaction when empty or emptied this cycle
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_acc);

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // register value with zero and oversize clamped
  logic [DIM_W-1:0] cfg_dim;
  always_comb begin
    if (cfg_i.data.value == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (32'(cfg_i.data.value) > MAX_FACE_DIM) begin
      cfg_dim = DIM_W'(MAX_FACE_DIM);
    end else begin
      cfg_dim = DIM_W'(cfg_i.data.value);
    end
  end

  // ---------------------------------------------------------------- face select
  logic [NUM_W-1:0] ax, ay, az, m_sel;
  logic signed [NUM_W:0] nu, nv, sum_u, sum_v;
  logic signed [NUM_W:0] sx, sy, sz;
  logic [2:0] face_sel;
  always_comb begin
    sx = (NUM_W+1)'(sample_i.data.dir_x);
    sy = (NUM_W+1)'(sample_i.data.dir_y);
    sz = (NUM_W+1)'(sample_i.data.dir_z);
    ax = sx[NUM_W] ? NUM_W'(-sx) : NUM_W'(sx);
    ay = sy[NUM_W] ? NUM_W'(-sy) : NUM_W'(sy);
    az = sz[NUM_W] ? NUM_W'(-sz) : NUM_W'(sz);
    if (ax >= az && ax >= ay) begin
      m_sel    = ax;
      face_sel = (sx > 0) ? FACE_POS_X : FACE_NEG_X;
      nu = -sz;
      nv = -sy;
    end else if (az >= ay) begin
      m_sel = az;
      nv    = -sy;
      if (sz > 0) begin
        face_sel = FACE_POS_Z;
        nu = -sx;
      end else begin
        face_sel = FACE_NEG_Z;
        nu = sx;
      end
    end else begin
      m_sel = ay;
      nu    = -sx;
      if (sy > 0) begin
        face_sel = FACE_POS_Y;
        nv = sz;
      end else begin
        face_sel = FACE_NEG_Y;
        nv = -sz;
      end
    end
    sum_u = $signed({1'b0, m_sel}) + nu;
    sum_v = $signed({1'b0, m_sel}) + nv;
  end

  // ---------------------------------------------------------------- load path
  logic              ld_ok;
  logic [ADDR_W-1:0] ld_addr;
  assign ld_ok = in_acc && (sample_i.data.kind == KIND_LOAD) &&
                 (32'(sample_i.data.load_face) < FACE_COUNT) &&
                 (32'(sample_i.data.load_col) < MAX_FACE_DIM) &&
                 (32'(sample_i.data.load_row) < MAX_FACE_DIM);
  assign ld_addr = ADDR_W'(ADDR_W'(sample_i.data.load_face) * ADDR_W'(FACE_SZ)
                 + ADDR_W'(sample_i.data.load_row) * ADDR_W'(MAX_FACE_DIM)
                 + ADDR_W'(sample_i.data.load_col));

  // ---------------------------------------------------------------- divider
  // one restoring step per cycle for u and v side by side
  logic [PROD_W-1:0] prod_u, prod_v;
  logic [NUM_W:0]    step_u, step_v;
  logic              qb_u, qb_v;
  assign prod_u = PROD_W'(num_u_q) * PROD_W'(width_q);
  assign prod_v = PROD_W'(num_v_q) * PROD_W'(height_q);
  always_comb begin
    step_u = {rem_u_q, quo_u_q[QW-1]};
    step_v = {rem_v_q, quo_v_q[QW-1]};
    qb_u   = (step_u >= {1'b0, dsr_q});
    qb_v   = (step_v >= {1'b0, dsr_q});
    if (qb_u) step_u = step_u - {1'b0, dsr_q};
    if (qb_v) step_v = step_v - {1'b0, dsr_q};
  end

  // ---------------------------------------------------------------- wrap / clamp
  logic [DIM_W-1:0] cw, rw;
  assign cw = (quo_u_q[QW-1:FRAC_BITS] == width_q)  ? '0 : quo_u_q[QW-1:FRAC_BITS];
  assign rw = (quo_v_q[QW-1:FRAC_BITS] == height_q) ? '0 : quo_v_q[QW-1:FRAC_BITS];

  // ---------------------------------------------------------------- texel ram
  logic [DIM_W-1:0]  rd_col, rd_row;
  logic [ADDR_W-1:0] rd_addr, ram_waddr;
  logic [23:0]       ram_rdata;
  logic              rd_en;
  always_comb begin
    rd_col = rd_cnt_q[0] ? c1_q : c0_q;
    rd_row = rd_cnt_q[1] ? r1_q : r0_q;
  end
  assign rd_addr = ADDR_W'(ADDR_W'(face_q) * ADDR_W'(FACE_SZ)
                 + ADDR_W'(rd_row) * ADDR_W'(MAX_FACE_DIM) + ADDR_W'(rd_col));
  assign rd_en     = (state_q == ST_READ) && !rd_cnt_q[2];
  assign ram_waddr = ld_addr;

  cmbs_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_texel_ram (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (ram_waddr),
    .wdata_i ({sample_i.data.load_red, sample_i.data.load_green,
               sample_i.data.load_blue}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- blend math
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  logic [FRAC_BITS:0] wx0, wx1, wy0, wy1;
  logic [TW-1:0]      top_d [3];
  logic [TW-1:0]      bot_d [3];
  logic [AW-1:0]      acc_d [3];
  assign wx1 = {1'b0, fx_q};
  assign wx0 = ONE - wx1;
  assign wy1 = {1'b0, fy_q};
  assign wy0 = ONE - wy1;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top_d[ch] = TW'(texel_q[0][23-8*ch -: 8]) * TW'(wx0)
                + TW'(texel_q[1][23-8*ch -: 8]) * TW'(wx1);
      bot_d[ch] = TW'(texel_q[2][23-8*ch -: 8]) * TW'(wx0)
                + TW'(texel_q[3][23-8*ch -: 8]) * TW'(wx1);
      acc_d[ch] = AW'(top_q[ch]) * AW'(wy0) + AW'(bot_q[ch]) * AW'(wy1)
                + (AW'(1) << (2*FRAC_BITS - 1));
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= DIM_W'(DIM_RST);
      height_q    <= DIM_W'(DIM_RST);
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      face_q      <= '0;
      black_q     <= 1'b0;
      num_u_q     <= '0;
      num_v_q     <= '0;
      dsr_q       <= '0;
      rem_u_q     <= '0;
      rem_v_q     <= '0;
      quo_u_q     <= '0;
      quo_v_q     <= '0;
      div_cnt_q   <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      r0_q        <= '0;
      r1_q        <= '0;
      fx_q        <= '0;
      fy_q        <= '0;
      rd_cnt_q    <= '0;
      for (int i = 0; i < 4; i++) texel_q[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        top_q[i]   <= '0;
        bot_q[i]   <= '0;
        color_q[i] <= '0;
      end
    end else begin
      if (cfg_acc) begin
        if (cfg_i.data.index == CFG_FACE_WIDTH)  width_q  <= cfg_dim;
        if (cfg_i.data.index == CFG_FACE_HEIGHT) height_q <= cfg_dim;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && sample_i.data.kind == KIND_SAMPLE) begin
            face_q  <= (m_sel == '0) ? FACE_POS_X : face_sel;
            num_u_q <= sum_u[NUM_W-1:0];
            num_v_q <= sum_v[NUM_W-1:0];
            dsr_q   <= NUM_W'({m_sel, 1'b0});
            for (int i = 0; i < 3; i++) color_q[i] <= '0;
            // zero direction or a zero coordinate gives black
            black_q <= (m_sel == '0) || (sum_u == '0) || (sum_v == '0);
            state_q <= ((m_sel == '0) || (sum_u == '0) || (sum_v == '0))
                       ? ST_OUT : ST_MUL;
          end
        end
        ST_MUL: begin
          rem_u_q   <= prod_u[PROD_W-1 -: NUM_W];
          rem_v_q   <= prod_v[PROD_W-1 -: NUM_W];
          quo_u_q   <= QW'({prod_u, {FRAC_BITS{1'b0}}});
          quo_v_q   <= QW'({prod_v, {FRAC_BITS{1'b0}}});
          div_cnt_q <= CNT_W'(QW);
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          rem_u_q   <= step_u[NUM_W-1:0];
          rem_v_q   <= step_v[NUM_W-1:0];
          quo_u_q   <= {quo_u_q[QW-2:0], qb_u};
          quo_v_q   <= {quo_v_q[QW-2:0], qb_v};
          div_cnt_q <= div_cnt_q - CNT_W'(1);
          if (div_cnt_q == CNT_W'(1)) state_q <= ST_WRAP;
        end
        ST_WRAP: begin
          c0_q     <= cw;
          r0_q     <= rw;
          c1_q     <= ((DIM_W+1)'(cw) + 1'b1 < (DIM_W+1)'(width_q))  ? cw + 1'b1 : cw;
          r1_q     <= ((DIM_W+1)'(rw) + 1'b1 < (DIM_W+1)'(height_q)) ? rw + 1'b1 : rw;
          fx_q     <= quo_u_q[FRAC_BITS-1:0];
          fy_q     <= quo_v_q[FRAC_BITS-1:0];
          rd_cnt_q <= '0;
          state_q  <= ST_READ;
        end
        ST_READ: begin
          // address k goes out at count k, its data lands at count k+1
          if (rd_cnt_q != '0) texel_q[rd_cnt_q[1:0] - 2'd1] <= ram_rdata;
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q == 3'd4) state_q <= ST_BLEND1;
        end
        ST_BLEND1: begin
          for (int i = 0; i < 3; i++) begin
            top_q[i] <= top_d[i];
            bot_q[i] <= bot_d[i];
          end
          state_q <= ST_BLEND2;
        end
        ST_BLEND2: begin
          for (int i = 0; i < 3; i++) color_q[i] <= acc_d[i][2*FRAC_BITS +: 8];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_q.hit_face  <= face_q;
            out_data_q.out_red   <= black_q ? 8'd0 : color_q[0];
            out_data_q.out_green <= black_q ? 8'd0 : color_q[1];
            out_data_q.out_blue  <= black_q ? 8'd0 : color_q[2];
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/cmbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbs_checker
// port-level checks of the cube map sampler, bound to the top level
// ----------------------------------------------------------------------------
module cmbs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_kind_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input cmbs_pkg::result_t res_data_i
);
  import cmbs_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_data_i))
    else $error("result payload changed while stalled");

  // a sample transaction occupies the engine for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == KIND_SAMPLE
    |=> !in_ready_i)
    else $error("item taken while a sample is in flight");

  // the reported face is a real face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.hit_face <= FACE_NEG_Y))
    else $error("bad hit face");

endmodule

bind cube_map_bilinear_sampler_top cmbs_checker u_cmbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_kind_i   (sample_i.data.kind),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_data_i  (result_o.data)
);

FILE: tb/sv/cube_map_bilinear_sampler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube map bilinear sampler testbench
// loads texels, samples directions and compares every result with a
// predictor of face select, wrap/clamp and bilinear blend; random gaps and
// stalls on both sides, several face sizes written between phases
// ----------------------------------------------------------------------------
module cube_map_bilinear_sampler_top_test;
  import cmbs_pkg::*;

  localparam int unsigned DIM = 64;
  localparam int unsigned FRB = 8;
  localparam int unsigned WATCHDOG_CYCLES = 20000;
  // extra settle time at the end of wait_drained
  localparam int unsigned DRAIN_CYCLES = 60;

  logic clk_i;
  logic rst_ni;

  cmbs_item_if   sample_if ();
  cmbs_result_if result_if ();
  cmbs_cfg_if    cfg_if ();

  cube_map_bilinear_sampler_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if.sink),
    .result_o(result_if.source),
    .cfg_i   (cfg_if.sink)
  );

  // predictor state: texel copy, written flags and face size
  logic [23:0] texel_mem [FACE_COUNT*DIM*DIM];
  bit          texel_set [FACE_COUNT*DIM*DIM];
  int unsigned cur_width, cur_height;

  item_t   pending_items [$];
  result_t expected_colors [$];
  bit      failed;
  int      stall_hold;      // long receiver hold-off, counted down by the ready driver
  int unsigned idle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned texel_index(int unsigned f, int unsigned c, int unsigned r);
    return (f * DIM + r) * DIM + c;
  endfunction

  // face select and face coordinate numerators for a direction
  function automatic void project_dir(input item_t it, output int unsigned face,
                                      output int unsigned m, output int nu, output int nv);
    int dx, dy, dz, ax, ay, az;
    dx = it.dir_x; dy = it.dir_y; dz = it.dir_z;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    if (ax >= az && ax >= ay) begin
      m = ax; face = dx > 0 ? FACE_POS_X : FACE_NEG_X;
      nu = -dz; nv = -dy;
    end else if (az >= ay) begin
      m = az; nv = -dy;
      if (dz > 0) begin face = FACE_POS_Z; nu = -dx; end
      else begin face = FACE_NEG_Z; nu = dx; end
    end else begin
      m = ay; nu = -dx;
      if (dy > 0) begin face = FACE_POS_Y; nv = dz; end
      else begin face = FACE_NEG_Y; nv = -dz; end
    end
  endfunction

  // neighbor texel addresses of a sample; returns 0 when it lands on black
  function automatic bit sample_taps(input item_t it, output int unsigned face,
                                     output int unsigned c0, output int unsigned c1,
                                     output int unsigned r0, output int unsigned r1,
                                     output int unsigned fx, output int unsigned fy);
    int unsigned m, numu, numv;
    int nu, nv;
    longint unsigned tu, tv;
    project_dir(it, face, m, nu, nv);
    c0 = 0; c1 = 0; r0 = 0; r1 = 0; fx = 0; fy = 0;
    if (m == 0) begin
      face = FACE_POS_X;
      return 1'b0;
    end
    numu = int'(m) + nu;
    numv = int'(m) + nv;
    if (numu == 0 || numv == 0) return 1'b0;
    tu = ((longint'(numu) * cur_width) << FRB) / (2 * longint'(m));
    tv = ((longint'(numv) * cur_height) << FRB) / (2 * longint'(m));
    fx = tu % (1 << FRB);
    fy = tv % (1 << FRB);
    c0 = (tu >> FRB) % cur_width;
    r0 = (tv >> FRB) % cur_height;
    c1 = (c0 + 1 < cur_width) ? c0 + 1 : c0;
    r1 = (r0 + 1 < cur_height) ? r0 + 1 : r0;
    return 1'b1;
  endfunction

  function automatic result_t predict_color(input item_t it);
    result_t res;
    int unsigned face, c0, c1, r0, r1, fx, fy, one;
    logic [23:0] ta, tb, tc, td;
    longint unsigned top, bot, acc;
    one = 1 << FRB;
    res = '0;
    if (sample_taps(it, face, c0, c1, r0, r1, fx, fy)) begin
      ta = texel_mem[texel_index(face, c0, r0)];
      tb = texel_mem[texel_index(face, c1, r0)];
      tc = texel_mem[texel_index(face, c0, r1)];
      td = texel_mem[texel_index(face, c1, r1)];
      for (int ch = 0; ch < 3; ch++) begin
        top = ta[16-8*ch +: 8] * (one - fx) + tb[16-8*ch +: 8] * fx;
        bot = tc[16-8*ch +: 8] * (one - fx) + td[16-8*ch +: 8] * fx;
        acc = top * (one - fy) + bot * fy + (1 << (2*FRB-1));
        case (ch)
          0: res.out_red   = acc >> (2*FRB);
          1: res.out_green = acc >> (2*FRB);
          default: res.out_blue = acc >> (2*FRB);
        endcase
      end
    end
    res.hit_face = face;
    return res;
  endfunction

  // true when every tap of the sample was written, or when it lands on black
  function automatic bit taps_written(input item_t it);
    int unsigned face, c0, c1, r0, r1, fx, fy;
    if (!sample_taps(it, face, c0, c1, r0, r1, fx, fy)) return 1'b1;
    return texel_set[texel_index(face, c0, r0)] && texel_set[texel_index(face, c1, r0)] &&
           texel_set[texel_index(face, c0, r1)] && texel_set[texel_index(face, c1, r1)];
  endfunction

  // texel writes and predictions happen in acceptance order in the accept block
  function automatic item_t load_item(int unsigned f, int unsigned c, int unsigned r);
    item_t it;
    it = {$urandom, $urandom};
    it.kind = KIND_LOAD;
    it.load_face = f; it.load_col = c; it.load_row = r;
    it.load_red = 8'($urandom);
    return it;
  endfunction

  function automatic item_t sample_item(int dx, int dy, int dz);
    item_t it;
    it = {$urandom, $urandom};
    it.kind = KIND_SAMPLE;
    it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
    return it;
  endfunction

  // random direction, mostly inside Q2.14 unit range, sometimes full range
  function automatic item_t random_sample();
    case ($urandom_range(0, 5))
      0: return sample_item($urandom, $urandom, $urandom);
      1: return sample_item(16384 - 32768 * $urandom_range(0, 1), $urandom_range(0, 32767)
                            - 16384, $urandom_range(0, 32767) - 16384);
      2: return sample_item($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                            $urandom_range(0, 8) - 4);
      default: return sample_item($urandom_range(0, 32767) - 16384,
                                  $urandom_range(0, 32767) - 16384,
                                  $urandom_range(0, 32767) - 16384);
    endcase
  endfunction

  // ---------------------------------------------------------------- accept
  // transactions are seen at the rising edge; texel copy and predictions
  // are updated here in acceptance order
  bit in_taken;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= sample_if.valid && sample_if.ready;
      if (sample_if.valid && sample_if.ready) begin
        if (sample_if.data.kind == KIND_LOAD) begin
          if (sample_if.data.load_face < FACE_COUNT) begin
            texel_mem[texel_index(sample_if.data.load_face, sample_if.data.load_col,
                                  sample_if.data.load_row)] =
              {sample_if.data.load_red, sample_if.data.load_green, sample_if.data.load_blue};
          end
        end else begin
          expected_colors.push_back(predict_color(sample_if.data));
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver
  int sender_wait;
  bit sender_pause;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      sample_if.data  <= '0;
      sender_wait     <= 0;
    end else begin
      if (sample_if.valid && !in_taken) begin
        // hold the current transaction
      end else if (sender_wait > 0) begin
        sample_if.valid <= 1'b0;
        sender_wait <= sender_wait - 1;
      end else if (pending_items.size() > 0 && !sender_pause) begin
        sample_if.valid <= 1'b1;
        sample_if.data  <= pending_items.pop_front();
        sender_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int receiver_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiver_wait <= 0;
    end else if (result_if.valid && result_if.ready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, result_if.data);
        failed = 1'b1;
      end else begin
        result_t exp_res;
        exp_res = expected_colors.pop_front();
        if (exp_res.hit_face !== result_if.data.hit_face)
          $display("%0t: hit_face expected %0d actual %0d", $time, exp_res.hit_face,
                   result_if.data.hit_face);
        if (exp_res.out_red !== result_if.data.out_red)
          $display("%0t: out_red expected %0d actual %0d", $time, exp_res.out_red,
                   result_if.data.out_red);
        if (exp_res.out_green !== result_if.data.out_green)
          $display("%0t: out_green expected %0d actual %0d", $time, exp_res.out_green,
                   result_if.data.out_green);
        if (exp_res.out_blue !== result_if.data.out_blue)
          $display("%0t: out_blue expected %0d actual %0d", $time, exp_res.out_blue,
                   result_if.data.out_blue);
        if (exp_res !== result_if.data) failed = 1'b1;
      end
      receiver_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
    end else if (receiver_wait > 0) begin
      receiver_wait <= receiver_wait - 1;
    end
  end

  // ready changes on the falling edge only
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_if.ready <= 1'b0;
    else if (stall_hold > 0) begin
      result_if.ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else result_if.ready <= (receiver_wait == 0) && !(result_if.valid && result_if.ready);
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        stall_hold > 0)
      idle_count <= 0;
    else begin
      idle_count <= idle_count + 1;
      if (idle_count == WATCHDOG_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- sequencing
  task automatic wait_drained();
    while (pending_items.size() > 0 || sample_if.valid || expected_colors.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write; the predictor clamps the value as the block does
  task automatic write_size(logic [1:0] idx, logic [6:0] val);
    int unsigned dim;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    dim = (val == 0) ? 1 : (val > DIM ? DIM : val);
    if (idx == CFG_FACE_WIDTH) cur_width = dim;
    else if (idx == CFG_FACE_HEIGHT) cur_height = dim;
  endtask

  // fill the active region of every face so any sample reads written texels
  task automatic load_faces();
    for (int f = 0; f < FACE_COUNT; f++)
      for (int r = 0; r < cur_height; r++)
        for (int c = 0; c < cur_width; c++) begin
          pending_items.push_back(load_item(f, c, r));
          texel_set[texel_index(f, c, r)] = 1'b1;
        end
  endtask

  // random phase: samples mixed with reloads, only safe samples are queued
  task automatic random_phase(int count);
    item_t it;
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) == 0) begin
        it = load_item($urandom_range(0, 7), $urandom_range(0, cur_width - 1),
                       $urandom_range(0, cur_height - 1));
        if (it.load_face < FACE_COUNT)
          texel_set[texel_index(it.load_face, it.load_col, it.load_row)] = 1'b1;
        pending_items.push_back(it);
      end else begin
        it = random_sample();
        if (taps_written(it)) pending_items.push_back(it);
      end
      n++;
    end
  endtask

  initial begin
    int sizes [4][2] = '{'{1, 1}, '{4, 3}, '{0, 6}, '{127, 0}};
    failed = 1'b0;
    stall_hold = 0;
    sender_pause = 1'b0;
    cur_width = DIM; cur_height = DIM;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: small face, extremes, zero direction, black edges, ties
    write_size(CFG_FACE_WIDTH, 2);
    write_size(CFG_FACE_HEIGHT, 2);
    load_faces();
    pending_items.push_back(load_item(6, 0, 0));
    pending_items.push_back(load_item(7, 63, 63));
    pending_items.push_back(sample_item(0, 0, 0));
    pending_items.push_back(sample_item(16384, 0, 0));
    pending_items.push_back(sample_item(-16384, 0, 0));
    pending_items.push_back(sample_item(0, 0, 16384));
    pending_items.push_back(sample_item(0, 0, -16384));
    pending_items.push_back(sample_item(0, 16384, 0));
    pending_items.push_back(sample_item(0, -16384, 0));
    pending_items.push_back(sample_item(16384, 0, 16384));
    pending_items.push_back(sample_item(16384, 16384, 16384));
    pending_items.push_back(sample_item(0, 16384, 16384));
    pending_items.push_back(sample_item(32767, -32768, 32767));
    pending_items.push_back(sample_item(-32768, -32768, -32768));
    pending_items.push_back(sample_item(-32768, 32767, 1));
    pending_items.push_back(sample_item(1, -1, 1));
    wait_drained();

    // receiver stalls long while loads and samples pile up
    stall_hold = 300;
    random_phase(60);
    wait_drained();

    foreach (sizes[i]) begin
      write_size(CFG_FACE_WIDTH, 7'(sizes[i][0]));
      write_size(CFG_FACE_HEIGHT, 7'(sizes[i][1]));
      load_faces();
      random_phase(40);
      wait_drained();
    end

    // sender pauses with work queued until every expected result has come
    random_phase(20);
    sender_pause = 1'b1;
    while (sample_if.valid || expected_colors.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sender_pause = 1'b0;
    wait_drained();

    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
